/* design/cbfm_pkg.sv */
// Shared types and constants of the clock buffer frame manager.
package cbfm_pkg;

    localparam int NUM_FRAMES_DEF = 16;
    localparam int PIN_BITS_DEF   = 8;

    localparam int CFG_W   = 5;
    localparam int KIND_W  = 3;
    localparam int FILE_W  = 8;
    localparam int PAGE_W  = 32;
    localparam int STAT_W  = 3;
    localparam int FRAME_W = 4;

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_READ    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ALLOC   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_UNPIN   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DISPOSE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_FLUSH   = 3'd4;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK          = 3'd0;
    localparam logic [STAT_W-1:0] ST_NO_FREE     = 3'd1;
    localparam logic [STAT_W-1:0] ST_NOT_PRESENT = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOT_PINNED  = 3'd3;
    localparam logic [STAT_W-1:0] ST_PRESENT     = 3'd4;
    localparam logic [STAT_W-1:0] ST_PAGE_PINNED = 3'd5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_SWEEP,
        S_FLUSH,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [FRAME_W-1:0] frame;
        logic               hit;
        logic               writeback;
        logic [FILE_W-1:0]  wb_file;
        logic [PAGE_W-1:0]  wb_page;
        logic               last;
    } res_t;

endpackage

/* design/cbfm_obuf.sv */
// Output register that parts the sequencer from the result stream.
module cbfm_obuf
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  cbfm_pkg::res_t in_res,
    output logic           m_tvalid,
    input  logic           m_tready,
    // status, frame, hit, writeback, wb_file, wb_page, then zero fill
    output logic [55:0]    m_tdata,
    output logic           m_tlast
);

    logic           valid_reg;
    cbfm_pkg::res_t res_reg;

    assign in_ready = !valid_reg || m_tready;

    // Hold the word until taken, load a new one when free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            res_reg <= in_res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {7'd0, res_reg.wb_page, res_reg.wb_file, res_reg.writeback,
                       res_reg.hit, res_reg.frame, res_reg.status};
    assign m_tlast  = res_reg.last;

endmodule

/* design/clock_buffer_frame_manager.sv */
// Frame table with clock replacement, driven by a one-frame-per-cycle sequencer.
// Steps: tag search visits one frame at a time up to the active frames; a miss on read
// or alloc adds a clock sweep of up to two rounds of the hand; flush scans the active
// frames and reports each frame it releases; each result then passes the output register.
// One request at a time: a new request is taken only once the last result is handed on.
// Reset: all frames invalid and unpinned, active_frames = NUM_FRAMES, hand at last frame.
module clock_buffer_frame_manager
#(
    parameter int NUM_FRAMES = cbfm_pkg::NUM_FRAMES_DEF,
    parameter int PIN_BITS   = cbfm_pkg::PIN_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // kind, file_id, page_no, set_dirty, then zero fill
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status, frame, hit, writeback, wb_file, wb_page, then zero fill
    output logic [55:0] m_tdata,
    output logic        m_tlast
);

    localparam int IW = $clog2(NUM_FRAMES);
    localparam int CW = $clog2(NUM_FRAMES + 1);
    localparam int SW = CW + 1;
    localparam logic [PIN_BITS-1:0] PIN_MAX = {PIN_BITS{1'b1}};

    // Frame state
    logic                        valid_reg [NUM_FRAMES];
    logic                        valid_next[NUM_FRAMES];
    logic                        ref_reg   [NUM_FRAMES];
    logic                        ref_next  [NUM_FRAMES];
    logic                        dirty_reg [NUM_FRAMES];
    logic                        dirty_next[NUM_FRAMES];
    logic [PIN_BITS-1:0]         pins_reg  [NUM_FRAMES];
    logic [PIN_BITS-1:0]         pins_next [NUM_FRAMES];
    logic [cbfm_pkg::FILE_W-1:0] tagf_reg  [NUM_FRAMES];
    logic [cbfm_pkg::PAGE_W-1:0] tagp_reg  [NUM_FRAMES];

    cbfm_pkg::state_t            state_reg, state_next;
    logic [CW-1:0]               act_reg;
    logic [IW-1:0]               hand_reg, hand_next;
    logic [CW-1:0]               ptr_reg, ptr_next;
    logic [SW-1:0]               step_reg, step_next;
    logic                        ret_flush_reg, ret_flush_next;
    logic                        pend_reg, pend_next;
    cbfm_pkg::res_t              pend_res_reg, pend_res_next;
    cbfm_pkg::res_t              res_reg, res_next;
    logic [cbfm_pkg::KIND_W-1:0] kind_reg;
    logic [cbfm_pkg::FILE_W-1:0] file_reg;
    logic [cbfm_pkg::PAGE_W-1:0] page_reg;
    logic                        sd_reg;

    logic                        tag_we;
    logic [IW-1:0]               hand_inc;
    logic [IW-1:0]               idx;
    logic                        file_eq;
    logic                        match;
    logic                        last_ptr;
    logic [CW-1:0]               cfg_eff;
    logic                        ob_ready;
    logic                        accept;

    assign s_tready = (state_reg == cbfm_pkg::S_IDLE);
    assign accept   = s_tvalid && s_tready;

    // Clamp the written frame count to 1..NUM_FRAMES
    always_comb
    begin
        if (cfg_wdata == 5'd0)
        begin
            cfg_eff = CW'(1);
        end
        else if (32'(cfg_wdata) > NUM_FRAMES)
        begin
            cfg_eff = CW'(NUM_FRAMES);
        end
        else
        begin
            cfg_eff = CW'(cfg_wdata);
        end
    end

    // Shared frame lookup: one frame read per cycle
    assign hand_inc = ((CW'(hand_reg) + CW'(1)) == act_reg) ? '0 : IW'(hand_reg + IW'(1));
    assign idx      = (state_reg == cbfm_pkg::S_SWEEP) ? hand_inc : ptr_reg[IW-1:0];
    assign file_eq  = valid_reg[idx] && (tagf_reg[idx] == file_reg);
    assign match    = file_eq && (tagp_reg[idx] == page_reg);
    assign last_ptr = (ptr_reg == (act_reg - CW'(1)));

    // Sequencer
    always_comb
    begin
        valid_next     = valid_reg;
        ref_next       = ref_reg;
        dirty_next     = dirty_reg;
        pins_next      = pins_reg;
        state_next     = state_reg;
        hand_next      = hand_reg;
        ptr_next       = ptr_reg;
        step_next      = step_reg;
        ret_flush_next = ret_flush_reg;
        pend_next      = pend_reg;
        pend_res_next  = pend_res_reg;
        res_next       = res_reg;
        tag_we         = 1'b0;

        unique case (state_reg)
            cbfm_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    ptr_next       = '0;
                    step_next      = '0;
                    pend_next      = 1'b0;
                    ret_flush_next = 1'b0;
                    if (s_tdata[2:0] == cbfm_pkg::KIND_FLUSH)
                    begin
                        state_next = cbfm_pkg::S_FLUSH;
                    end
                    else if (s_tdata[2:0] < cbfm_pkg::KIND_FLUSH)
                    begin
                        state_next = cbfm_pkg::S_FIND;
                    end
                end
            end

            cbfm_pkg::S_FIND:
            begin
                res_next        = '0;
                res_next.last   = 1'b1;
                if (match)
                begin
                    res_next.frame = cbfm_pkg::FRAME_W'(idx);
                    res_next.hit   = 1'b1;
                    state_next     = cbfm_pkg::S_OUT;
                    case (kind_reg)
                        cbfm_pkg::KIND_READ:
                        begin
                            ref_next[idx] = 1'b1;
                            if (pins_reg[idx] != PIN_MAX)
                            begin
                                pins_next[idx] = pins_reg[idx] + PIN_BITS'(1);
                            end
                        end
                        cbfm_pkg::KIND_ALLOC:
                        begin
                            res_next.status = cbfm_pkg::ST_PRESENT;
                        end
                        cbfm_pkg::KIND_UNPIN:
                        begin
                            if (pins_reg[idx] == '0)
                            begin
                                res_next.status = cbfm_pkg::ST_NOT_PINNED;
                            end
                            else
                            begin
                                pins_next[idx] = pins_reg[idx] - PIN_BITS'(1);
                                if (sd_reg)
                                begin
                                    dirty_next[idx] = 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                            valid_next[idx] = 1'b0;
                            ref_next[idx]   = 1'b0;
                            dirty_next[idx] = 1'b0;
                            pins_next[idx]  = '0;
                        end
                    endcase
                end
                else if (last_ptr)
                begin
                    if (kind_reg == cbfm_pkg::KIND_READ || kind_reg == cbfm_pkg::KIND_ALLOC)
                    begin
                        state_next = cbfm_pkg::S_SWEEP;
                    end
                    else
                    begin
                        res_next.status = cbfm_pkg::ST_NOT_PRESENT;
                        state_next      = cbfm_pkg::S_OUT;
                    end
                end
                else
                begin
                    ptr_next = ptr_reg + CW'(1);
                end
            end

            cbfm_pkg::S_SWEEP:
            begin
                // Advance the hand, then give the frame its second chance
                hand_next     = hand_inc;
                res_next      = '0;
                res_next.last = 1'b1;
                if (!valid_reg[idx] || (!ref_reg[idx] && pins_reg[idx] == '0))
                begin
                    res_next.frame = cbfm_pkg::FRAME_W'(idx);
                    if (valid_reg[idx] && dirty_reg[idx])
                    begin
                        res_next.writeback = 1'b1;
                        res_next.wb_file   = tagf_reg[idx];
                        res_next.wb_page   = tagp_reg[idx];
                    end
                    valid_next[idx] = 1'b1;
                    ref_next[idx]   = 1'b1;
                    dirty_next[idx] = 1'b0;
                    pins_next[idx]  = PIN_BITS'(1);
                    tag_we          = 1'b1;
                    state_next      = cbfm_pkg::S_OUT;
                end
                else
                begin
                    if (ref_reg[idx])
                    begin
                        ref_next[idx] = 1'b0;
                    end
                    if (step_reg == ({1'b0, act_reg} + {1'b0, act_reg} - SW'(1)))
                    begin
                        res_next.status = cbfm_pkg::ST_NO_FREE;
                        state_next      = cbfm_pkg::S_OUT;
                    end
                    else
                    begin
                        step_next = step_reg + SW'(1);
                    end
                end
            end

            cbfm_pkg::S_FLUSH:
            begin
                if (ptr_reg == act_reg)
                begin
                    // End of scan: release the held word or report nothing found
                    if (pend_reg)
                    begin
                        res_next = pend_res_reg;
                    end
                    else
                    begin
                        res_next = '0;
                    end
                    res_next.last  = 1'b1;
                    pend_next      = 1'b0;
                    ret_flush_next = 1'b0;
                    state_next     = cbfm_pkg::S_OUT;
                end
                else if (file_eq)
                begin
                    if (pend_reg)
                    begin
                        // Send the held word first, revisit this frame after
                        res_next       = pend_res_reg;
                        res_next.last  = 1'b0;
                        pend_next      = 1'b0;
                        ret_flush_next = 1'b1;
                        state_next     = cbfm_pkg::S_OUT;
                    end
                    else if (pins_reg[idx] != '0)
                    begin
                        res_next         = '0;
                        res_next.status  = cbfm_pkg::ST_PAGE_PINNED;
                        res_next.frame   = cbfm_pkg::FRAME_W'(idx);
                        res_next.hit     = 1'b1;
                        res_next.wb_file = tagf_reg[idx];
                        res_next.wb_page = tagp_reg[idx];
                        res_next.last    = 1'b1;
                        ret_flush_next   = 1'b0;
                        state_next       = cbfm_pkg::S_OUT;
                    end
                    else
                    begin
                        pend_res_next           = '0;
                        pend_res_next.frame     = cbfm_pkg::FRAME_W'(idx);
                        pend_res_next.hit       = 1'b1;
                        pend_res_next.writeback = dirty_reg[idx];
                        pend_res_next.wb_file   = tagf_reg[idx];
                        pend_res_next.wb_page   = tagp_reg[idx];
                        pend_next               = 1'b1;
                        valid_next[idx]         = 1'b0;
                        ref_next[idx]           = 1'b0;
                        dirty_next[idx]         = 1'b0;
                        pins_next[idx]          = '0;
                        ptr_next                = ptr_reg + CW'(1);
                    end
                end
                else
                begin
                    ptr_next = ptr_reg + CW'(1);
                end
            end

            cbfm_pkg::S_OUT:
            begin
                if (ob_ready)
                begin
                    state_next = ret_flush_reg ? cbfm_pkg::S_FLUSH : cbfm_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = cbfm_pkg::S_IDLE;
            end
        endcase
    end

    // Control and frame state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cbfm_pkg::S_IDLE;
            act_reg       <= CW'(NUM_FRAMES);
            hand_reg      <= IW'(NUM_FRAMES - 1);
            ptr_reg       <= '0;
            step_reg      <= '0;
            ret_flush_reg <= 1'b0;
            pend_reg      <= 1'b0;
            for (int i = 0; i < NUM_FRAMES; i++)
            begin
                valid_reg[i] <= 1'b0;
                ref_reg[i]   <= 1'b0;
                dirty_reg[i] <= 1'b0;
                pins_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            step_reg      <= step_next;
            ret_flush_reg <= ret_flush_next;
            pend_reg      <= pend_next;
            valid_reg     <= valid_next;
            ref_reg       <= ref_next;
            dirty_reg     <= dirty_next;
            pins_reg      <= pins_next;
            if (cfg_we)
            begin
                act_reg  <= cfg_eff;
                hand_reg <= IW'(cfg_eff - CW'(1));
            end
            else
            begin
                hand_reg <= hand_next;
            end
        end
    end

    // Payload registers and tag store
    always_ff @(posedge clk)
    begin
        res_reg      <= res_next;
        pend_res_reg <= pend_res_next;
        if (accept)
        begin
            kind_reg <= s_tdata[2:0];
            file_reg <= s_tdata[10:3];
            page_reg <= s_tdata[42:11];
            sd_reg   <= s_tdata[43];
        end
        if (tag_we)
        begin
            tagf_reg[idx] <= file_reg;
            tagp_reg[idx] <= page_reg;
        end
    end

    cbfm_obuf u_obuf
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (state_reg == cbfm_pkg::S_OUT),
        .in_ready (ob_ready),
        .in_res   (res_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Checks
    a_act_range: assert property (@(posedge clk) disable iff (!rst_n)
        (act_reg != '0) && (act_reg <= CW'(NUM_FRAMES)))
        else $error("frame count out of range");

    a_hand_range: assert property (@(posedge clk) disable iff (!rst_n)
        CW'(hand_reg) < act_reg)
        else $error("clock hand beyond active frames");

    a_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cbfm_pkg::S_SWEEP) |-> (step_reg < ({1'b0, act_reg} + {1'b0, act_reg})))
        else $error("sweep ran past two rounds");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cbfm_pkg::S_FIND) |-> (ptr_reg < act_reg))
        else $error("tag search ran past active frames");

endmodule

/* dv/cbfm_checker.sv */
// Frame table predictor and result comparator for the clock buffer frame manager.
module cbfm_checker
    import cbfm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata,
    input  logic        m_tlast,
    output int          err_count,
    output int          pending
);

    localparam int NF = NUM_FRAMES_DEF;
    localparam int PIN_MAX = (1 << PIN_BITS_DEF) - 1;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [FRAME_W-1:0] frame;
        logic               hit;
        logic               writeback;
        logic [FILE_W-1:0]  wb_file;
        logic [PAGE_W-1:0]  wb_page;
        logic               last;
    } outcome_t;

    // shadow frame table
    int                 n_active;
    bit                 f_valid [NF];
    bit                 f_ref   [NF];
    bit                 f_dirty [NF];
    int                 f_pins  [NF];
    logic [FILE_W-1:0]  f_file  [NF];
    logic [PAGE_W-1:0]  f_page  [NF];
    int                 hand;

    outcome_t expected_q[$];

    assign pending = expected_q.size();

    function automatic outcome_t mk(logic [2:0] st, int fr, bit h, bit wb,
                                    logic [7:0] wf, logic [31:0] wp, bit l);
        outcome_t o;
        o.status = st; o.frame = fr[3:0]; o.hit = h; o.writeback = wb;
        o.wb_file = wf; o.wb_page = wp; o.last = l;
        return o;
    endfunction

    function automatic int lookup(logic [7:0] fid, logic [31:0] pg);
        for (int i = 0; i < n_active; i++)
            if (f_valid[i] && f_file[i] == fid && f_page[i] == pg)
                return i;
        return -1;
    endfunction

    function automatic void wipe(int i);
        f_valid[i] = 0; f_ref[i] = 0; f_dirty[i] = 0; f_pins[i] = 0;
    endfunction

    // second-chance sweep, then install the new tag
    function automatic void claim_frame(logic [7:0] fid, logic [31:0] pg);
        int victim;
        bit wb;
        victim = -1;
        for (int s = 0; s < 2 * n_active && victim < 0; s++) begin
            hand = (hand + 1) % n_active;
            if (!f_valid[hand]) victim = hand;
            else if (f_ref[hand]) f_ref[hand] = 0;
            else if (f_pins[hand] == 0) victim = hand;
        end
        if (victim < 0) begin
            expected_q.push_back(mk(ST_NO_FREE, 0, 0, 0, 0, 0, 1));
            return;
        end
        wb = f_valid[victim] && f_dirty[victim];
        expected_q.push_back(mk(ST_OK, victim, 0, wb, wb ? f_file[victim] : 8'd0,
                                wb ? f_page[victim] : 32'd0, 1));
        f_valid[victim] = 1; f_ref[victim] = 1; f_dirty[victim] = 0;
        f_pins[victim] = 1; f_file[victim] = fid; f_page[victim] = pg;
    endfunction

    function automatic void apply_request(logic [47:0] d);
        logic [2:0]  kind;
        logic [7:0]  fid;
        logic [31:0] pg;
        bit          sd;
        int          m, n;
        kind = d[2:0]; fid = d[10:3]; pg = d[42:11]; sd = d[43];
        case (kind)
            KIND_READ: begin
                m = lookup(fid, pg);
                if (m >= 0) begin
                    f_ref[m] = 1;
                    if (f_pins[m] < PIN_MAX) f_pins[m]++;
                    expected_q.push_back(mk(ST_OK, m, 1, 0, 0, 0, 1));
                end
                else claim_frame(fid, pg);
            end
            KIND_ALLOC: begin
                m = lookup(fid, pg);
                if (m >= 0) expected_q.push_back(mk(ST_PRESENT, m, 1, 0, 0, 0, 1));
                else claim_frame(fid, pg);
            end
            KIND_UNPIN: begin
                m = lookup(fid, pg);
                if (m < 0) expected_q.push_back(mk(ST_NOT_PRESENT, 0, 0, 0, 0, 0, 1));
                else if (f_pins[m] == 0)
                    expected_q.push_back(mk(ST_NOT_PINNED, m, 1, 0, 0, 0, 1));
                else begin
                    f_pins[m]--;
                    if (sd) f_dirty[m] = 1;
                    expected_q.push_back(mk(ST_OK, m, 1, 0, 0, 0, 1));
                end
            end
            KIND_DISPOSE: begin
                m = lookup(fid, pg);
                if (m < 0) expected_q.push_back(mk(ST_NOT_PRESENT, 0, 0, 0, 0, 0, 1));
                else begin
                    wipe(m);
                    expected_q.push_back(mk(ST_OK, m, 1, 0, 0, 0, 1));
                end
            end
            KIND_FLUSH: begin
                n = 0;
                for (int i = 0; i < n_active; i++) begin
                    if (!f_valid[i] || f_file[i] != fid) continue;
                    if (f_pins[i] > 0) begin
                        expected_q.push_back(mk(ST_PAGE_PINNED, i, 1, 0,
                                                f_file[i], f_page[i], 1));
                        return;
                    end
                    expected_q.push_back(mk(ST_OK, i, 1, f_dirty[i],
                                            f_file[i], f_page[i], 0));
                    wipe(i);
                    n++;
                end
                if (n == 0) expected_q.push_back(mk(ST_OK, 0, 0, 0, 0, 0, 1));
                else expected_q[$].last = 1;
            end
            default: ;
        endcase
    endfunction

    // track config, requests and results
    always @(posedge clk or negedge rst_n)
    begin
        outcome_t want, got;
        int v;
        if (!rst_n)
        begin
            n_active = NF;
            hand = NF - 1;
            for (int i = 0; i < NF; i++)
            begin
                wipe(i);
                f_file[i] = 0;
                f_page[i] = 0;
            end
            expected_q.delete();
            err_count = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.status    = m_tdata[2:0];
                got.frame     = m_tdata[6:3];
                got.hit       = m_tdata[7];
                got.writeback = m_tdata[8];
                got.wb_file   = m_tdata[16:9];
                got.wb_page   = m_tdata[48:17];
                got.last      = m_tlast;
                if (expected_q.size() == 0)
                begin
                    err_count++;
                    if (err_count <= 10)
                        $display("unexpected result word: %h last %0d", m_tdata, m_tlast);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got !== want)
                    begin
                        err_count++;
                        if (err_count <= 10)
                            $display("mismatch: exp st=%0d fr=%0d hit=%0d wb=%0d f=%h p=%h l=%0d",
                                     want.status, want.frame, want.hit, want.writeback,
                                     want.wb_file, want.wb_page, want.last,
                                     " / got st=%0d fr=%0d hit=%0d wb=%0d f=%h p=%h l=%0d",
                                     got.status, got.frame, got.hit, got.writeback,
                                     got.wb_file, got.wb_page, got.last);
                    end
                end
            end
            if (s_tvalid && s_tready)
                apply_request(s_tdata);
            if (cfg_we)
            begin
                v = cfg_wdata;
                if (v < 1) v = 1;
                if (v > NF) v = NF;
                n_active = v;
                hand = v - 1;
            end
        end
    end

endmodule

/* dv/tb_top.sv */
// Stimulus, clocking and verdict for the clock buffer frame manager testbench.
module tb_top;
    import cbfm_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [4:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    logic        m_tlast;
    int          err_count;
    int          pending;
    int          cycles;
    int          burst_left;
    logic [7:0]  pool_file [4];
    logic [31:0] pool_page [4];

    clock_buffer_frame_manager dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    cbfm_checker checker_i (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .err_count(err_count), .pending(pending)
    );

    initial clk = 0;
    always
    begin
        #10 clk = 1;
        #10 clk = 0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 600000)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver stall pattern: phases of free flow, light stalling and heavy stalling
    always @(posedge clk)
    begin
        if ((cycles / 300) % 3 == 0) m_tready <= 1'b1;
        else if ((cycles / 300) % 3 == 1) m_tready <= ($urandom_range(0, 3) != 0);
        else m_tready <= ($urandom_range(0, 4) == 0);
    end

    // present one word, wait for acceptance, then idle per burst pattern
    task automatic send(logic [2:0] kind, logic [7:0] fid, logic [31:0] pg, bit sd);
        s_tdata  <= {4'b0, sd, pg, fid, kind};
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        if (burst_left > 0) burst_left--;
        else
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(0, 8);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic set_frames(int n);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= n[4:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // mostly sequences on a small tag pool so hits, pins and evictions occur
    task automatic random_phase(int count);
        int k;
        int pick;
        logic [2:0] kind;
        for (k = 0; k < count; k++)
        begin
            pick = $urandom_range(0, 3);
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5: kind = KIND_READ;
                6, 7, 8:          kind = KIND_ALLOC;
                9, 10, 11, 12, 13: kind = KIND_UNPIN;
                14, 15:           kind = KIND_DISPOSE;
                16, 17:           kind = KIND_FLUSH;
                default:          kind = 3'($urandom_range(5, 7));
            endcase
            if ($urandom_range(0, 9) == 0)
                send(kind, 8'($urandom), $urandom, 1'($urandom_range(0, 1)));
            else
                send(kind, pool_file[pick[1:0]] ^ 8'($urandom_range(0, 1)),
                     pool_page[pick[1:0]] + $urandom_range(0, 5), 1'($urandom_range(0, 1)));
        end
    endtask

    initial
    begin
        cycles     = 0;
        burst_left = 0;
        rst_n      = 0;
        cfg_we     = 0;
        cfg_wdata  = 0;
        s_tvalid   = 0;
        s_tdata    = 0;
        m_tready   = 0;
        pool_file  = '{8'h00, 8'hFF, 8'h5A, 8'hA5};
        pool_page  = '{32'h0, 32'hFFFF_FFF8, 32'h1234_5678, 32'h8000_0000};
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: extremes, every kind, corner cases
        send(KIND_UNPIN,   8'hFF, 32'hFFFF_FFFF, 1);   // unpin absent
        send(KIND_DISPOSE, 8'h00, 32'h0, 0);           // dispose absent
        send(KIND_FLUSH,   8'h33, 32'h0, 0);           // flush with nothing buffered
        send(KIND_READ,    8'hFF, 32'hFFFF_FFFF, 0);   // miss into invalid frame
        send(KIND_READ,    8'hFF, 32'hFFFF_FFFF, 0);   // hit
        send(KIND_ALLOC,   8'hFF, 32'hFFFF_FFFF, 0);   // already present
        send(KIND_ALLOC,   8'h00, 32'h0, 1);
        send(KIND_UNPIN,   8'h00, 32'h0, 1);           // dirty it
        send(KIND_UNPIN,   8'h00, 32'h0, 0);           // not pinned
        send(KIND_FLUSH,   8'hFF, 32'h0, 0);           // pinned: stops
        send(KIND_FLUSH,   8'h00, 32'h0, 0);           // dirty write-out
        send(KIND_DISPOSE, 8'hFF, 32'hFFFF_FFFF, 0);   // dispose while pinned
        send(3'd7,         8'h12, 32'h0, 1);           // ignored kind
        send(3'd5,         8'h12, 32'h0, 0);

        // one frame, then two: fill, pin, exhaust, evict dirty
        set_frames(0);
        send(KIND_READ,  8'h01, 32'h10, 0);
        send(KIND_READ,  8'h01, 32'h11, 0);            // no free frame (only one frame)
        send(KIND_UNPIN, 8'h01, 32'h10, 1);
        send(KIND_READ,  8'h01, 32'h12, 0);            // dirty victim write-back
        set_frames(2);
        send(KIND_READ,  8'h02, 32'h1, 0);
        send(KIND_READ,  8'h02, 32'h2, 0);
        send(KIND_READ,  8'h02, 32'h3, 0);             // all pinned
        // pin saturation
        repeat (260) send(KIND_READ, 8'h02, 32'h1, 0);
        send(KIND_FLUSH, 8'h02, 32'h0, 0);

        // random phases across settings
        set_frames(16);
        random_phase(30);
        set_frames(3);
        random_phase(30);
        set_frames(31);
        random_phase(20);
        set_frames(1);
        random_phase(20);
        set_frames(8);
        random_phase(40);

        drain();
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
